// File: hw/rtl/lpf_pkg.sv
// Package for the link packet framer: word types and fixed header constants.
// No dependencies; used by link_packet_framer_top.
package lpf_pkg;

  localparam int unsigned HDR_LEN     = 9;
  localparam int unsigned MAX_RESULTS = 11;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0]  START_A   = 8'hFF;
  localparam logic [7:0]  START_B   = 8'h5A;
  localparam logic [7:0]  ACK_FLAG  = 8'h40;
  localparam logic [7:0]  SEQ_RESET = 8'h05;
  localparam logic [15:0] LEN_EXTRA = 16'd10;
  localparam logic [15:0] LEN_EMPTY = 16'd9;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_item;
    logic        last_item;
    logic [15:0] payload_length;
    logic [7:0]  control_byte;
    logic [7:0]  ack_number;
    logic [7:0]  session_id;
  } lpf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
  } lpf_out_t;

endpackage

// File: hw/rtl/link_packet_framer_top.sv
// Link packet framer: builds header, payload pass-through and checksums.
// Depends on lpf_pkg for word types and constants.
//
//   channel   dir   handshake              word
//   in        in    in_valid / in_ready    lpf_in_t  (one payload item)
//   out       out   out_valid / out_ready  lpf_out_t (one framed byte)
//
// each accepted word is turned combinationally into its result bytes and loaded
// into an 11-entry shift buffer that drains one byte per cycle on out while
// out_ready holds; payload words thus pass at one per cycle, but a closing word
// yields two bytes and a first word 10 or 11 bytes (9 for an empty packet).
// a new word is taken while the last buffered byte leaves, so in is held off
// while more than one byte waits, or while one waits under an out stall.
// rst (synchronous) empties the buffer, closes the packet, sequence = 5.
module link_packet_framer_top
  import lpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lpf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lpf_out_t out_data
);

  lpf_out_t         res_buf [MAX_RESULTS];
  lpf_out_t         res_buf_next [MAX_RESULTS];
  lpf_out_t         shifted [MAX_RESULTS];
  logic [CNT_W-1:0] res_cnt;
  logic [CNT_W-1:0] res_cnt_next;
  logic [7:0]       seq_num;
  logic [7:0]       seq_num_next;
  logic [7:0]       pay_sum;
  logic [7:0]       pay_sum_next;
  logic             pkt_open;
  logic             pkt_open_next;

  logic             load;
  logic             pop;
  logic             has_pay;
  logic [15:0]      total_len;
  logic [7:0]       hdr [HDR_LEN];
  logic [7:0]       hdr_sum;
  logic [7:0]       run_sum;
  logic [7:0]       pay_cks;

  assign out_valid = (res_cnt != '0);
  assign out_data  = res_buf[0];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (res_cnt == '0) || ((res_cnt == CNT_W'(1)) && out_ready);
  assign load      = in_valid && in_ready;

  always_comb begin
    has_pay   = (in_data.payload_length != '0);
    total_len = has_pay ? (in_data.payload_length + LEN_EXTRA) : LEN_EMPTY;
    hdr[0] = START_A;
    hdr[1] = START_B;
    hdr[2] = total_len[15:8];
    hdr[3] = total_len[7:0];
    hdr[4] = in_data.control_byte;
    hdr[5] = seq_num;
    hdr[6] = ((in_data.control_byte & ACK_FLAG) != '0) ? in_data.ack_number : '0;
    hdr[7] = in_data.session_id;
    hdr_sum = hdr[0] + hdr[1] + hdr[2] + hdr[3] + hdr[4] + hdr[5] + hdr[6] + hdr[7];
    hdr[8] = 8'(0) - hdr_sum;

    // a new packet restarts the payload sum
    run_sum = (in_data.first_item ? 8'd0 : pay_sum) + in_data.payload_byte;
    pay_cks = 8'(0) - run_sum;
  end

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (i == MAX_RESULTS - 1) begin
        shifted[i] = res_buf[i];
      end else begin
        shifted[i] = res_buf[i + 1];
      end
      res_buf_next[i] = '0;
    end
    res_cnt_next  = '0;
    seq_num_next  = seq_num;
    pay_sum_next  = pay_sum;
    pkt_open_next = pkt_open;

    if (in_data.first_item) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        res_buf_next[i].out_byte      = hdr[i];
        res_buf_next[i].end_of_packet = (i == HDR_LEN - 1) && !has_pay;
      end
      if (!has_pay) begin
        res_cnt_next  = CNT_W'(HDR_LEN);
        pay_sum_next  = '0;
        pkt_open_next = 1'b0;
      end else begin
        res_buf_next[HDR_LEN].out_byte      = in_data.payload_byte;
        res_buf_next[HDR_LEN].end_of_packet = 1'b0;
        res_buf_next[HDR_LEN + 1].out_byte      = pay_cks;
        res_buf_next[HDR_LEN + 1].end_of_packet = 1'b1;
        res_cnt_next  = CNT_W'(HDR_LEN + 1) + CNT_W'(in_data.last_item);
        pay_sum_next  = run_sum;
        pkt_open_next = 1'b1;
      end
    end else if (pkt_open) begin
      res_buf_next[0].out_byte      = in_data.payload_byte;
      res_buf_next[0].end_of_packet = 1'b0;
      res_buf_next[1].out_byte      = pay_cks;
      res_buf_next[1].end_of_packet = 1'b1;
      res_cnt_next = CNT_W'(1) + CNT_W'(in_data.last_item);
      pay_sum_next = run_sum;
    end

    // closing word of a non-empty packet
    if (in_data.last_item && (pkt_open_next && (in_data.first_item || pkt_open))) begin
      seq_num_next  = seq_num + 8'd1;
      pay_sum_next  = '0;
      pkt_open_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_buf <= res_buf_next;
    end else if (pop) begin
      res_buf <= shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt  <= '0;
      seq_num  <= SEQ_RESET;
      pay_sum  <= '0;
      pkt_open <= 1'b0;
    end else begin
      if (load) begin
        res_cnt  <= res_cnt_next;
        seq_num  <= seq_num_next;
        pay_sum  <= pay_sum_next;
        pkt_open <= pkt_open_next;
      end else if (pop) begin
        res_cnt <= res_cnt - CNT_W'(1);
      end
    end
  end

endmodule
